/* sv/bsrt_pkg.sv */
// Package for the block state range tracker.
// Shared types, command, status and state codes, and config register indexes.
// No dependencies.
package bsrt_pkg;

    typedef enum logic [2:0] {
        CMD_RCHECK = 3'd0,
        CMD_WCHECK = 3'd1,
        CMD_COMMIT = 3'd2,
        CMD_MARK   = 3'd3,
        CMD_LBEGIN = 3'd4,
        CMD_LFIN   = 3'd5
    } cmd_t;

    localparam logic [2:0] S_OK        = 3'd0;
    localparam logic [2:0] S_NOTLOADED = 3'd1;
    localparam logic [2:0] S_BOUNDS    = 3'd2;
    localparam logic [2:0] S_WAIT      = 3'd3;
    localparam logic [2:0] S_ILLEGAL   = 3'd4;

    localparam logic [1:0] ST_NDEF = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_CHNG = 2'd3;

    localparam logic [2:0] REG_BLOCK_SHIFT = 3'd0;
    localparam logic [2:0] REG_PART_SIZE   = 3'd1;
    localparam logic [2:0] REG_PHYS_BASE   = 3'd2;
    localparam logic [2:0] REG_TRACK       = 3'd3;
    localparam logic [2:0] REG_SAVE        = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [23:0] offset;
        logic [24:0] length;
        logic        load_ok;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [39:0] phys_addr;
        logic [24:0] byte_count;
        logic [9:0]  first_block;
        logic [10:0] block_count;
        logic        enqueue_changed;
    } out_item_t;

    typedef enum logic [3:0] {
        FSM_IDLE,
        FSM_CLEAR,
        FSM_SETUP,
        FSM_CHK_RD,
        FSM_CHK_WAIT,
        FSM_UPD_RD,
        FSM_UPD_WAIT,
        FSM_LB_RD,
        FSM_LB_WAIT,
        FSM_DONE
    } fsm_t;

    // Store access request from the sequencer.
    typedef struct packed {
        logic        rd_en;
        logic [15:0] rd_addr;
        logic        wr_en;
        logic [15:0] wr_addr;
        logic [1:0]  wr_data;
    } mem_req_t;

endpackage

/* sv/bsrt_store.sv */
// Block state store: one synchronous memory of two-bit states.
// Depends on bsrt_pkg for the request struct.
module bsrt_store #(
    parameter int NUM_BLOCKS = 1024,
    parameter int AW = 10
) (
    input  logic               aclk,
    input  bsrt_pkg::mem_req_t req,
    output logic [1:0]         rd_data
);
    logic [1:0] mem [NUM_BLOCKS];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr[AW-1:0]];
        end
    end
endmodule

/* sv/block_state_range_tracker.sv */
// Block state range tracker.
// Usage: configuration writes arrive on cfg_valid/cfg_ready with cfg_index and
// cfg_data, and must be made only while no command is in flight; the block does
// not enforce this. Commands arrive on s_valid/s_ready as one packed item, and
// each command yields one result item on m_valid/m_ready.
// After reset a clearing pass writes every entry of the state store as
// undefined, one per cycle, during which no item is taken.
// Each command is handled by a sequencer around the state store, whose reads are
// registered, so the check pass visits each block in a read state and a wait
// state. A commit runs a check pass and then an update pass over the blocks.
// The result sits in an output register; the next item is accepted only after
// the result has been taken, so a stalled receiver holds both the result and
// the input.
// Must-wait and illegal results leave the state unchanged.
module block_state_range_tracker #(
    parameter int NUM_BLOCKS = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bsrt_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bsrt_pkg::out_item_t  m_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [27:0]          cfg_data
);
    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int PSH = $clog2(PAGE_BYTES);

    // Configuration registers.
    logic [3:0]  block_shift_reg;
    logic [24:0] part_size_reg;
    logic [27:0] phys_base_reg;
    logic        track_reg;
    logic        save_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_shift_reg <= 4'd9;
            part_size_reg   <= '0;
            phys_base_reg   <= '0;
            track_reg       <= 1'b1;
            save_reg        <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                bsrt_pkg::REG_BLOCK_SHIFT: block_shift_reg <= cfg_data[3:0];
                bsrt_pkg::REG_PART_SIZE:   part_size_reg   <= cfg_data[24:0];
                bsrt_pkg::REG_PHYS_BASE:   phys_base_reg   <= cfg_data;
                bsrt_pkg::REG_TRACK:       track_reg       <= cfg_data[0];
                bsrt_pkg::REG_SAVE:        save_reg        <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer state.
    bsrt_pkg::fsm_t state_reg, state_next;
    bsrt_pkg::in_item_t item_reg;
    logic [16:0] idx_reg, idx_next;
    logic [16:0] first_reg, last_reg;
    logic        head_reg, tail_reg;
    logic        did_reg, did_next;
    logic        part_changed_reg, maybe_init_reg;
    logic [15:0] pend_first_reg;
    logic [16:0] pend_count_reg;
    logic [16:0] limit_reg;
    logic [24:0] nbytes_reg, nbytes_next;
    logic        out_valid_reg;
    bsrt_pkg::out_item_t out_reg;
    logic        finish;
    bsrt_pkg::out_item_t res;

    bsrt_pkg::mem_req_t req;
    logic [1:0] rd_data;

    bsrt_store #(.NUM_BLOCKS(NUM_BLOCKS), .AW(AW)) u_store (
        .aclk(aclk), .req(req), .rd_data(rd_data)
    );

    assign s_ready = (state_reg == bsrt_pkg::FSM_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    // Setup arithmetic on the captured item.
    logic [25:0] end_off;
    logic [25:0] chk_size;
    logic [24:0] mask;
    logic [25:0] range_len;
    logic [25:0] range_end;
    logic [25:0] first_w, last_w, cap_w, lim_w;
    logic        is_check;

    always_comb begin
        is_check = (item_reg.cmd == bsrt_pkg::CMD_RCHECK) ||
                   (item_reg.cmd == bsrt_pkg::CMD_WCHECK);
        chk_size = {1'b0, part_size_reg} - {2'b0, item_reg.offset};
        if (chk_size > {1'b0, item_reg.length}) chk_size = {1'b0, item_reg.length};
        range_len = is_check ? chk_size : {1'b0, item_reg.length};
        range_end = {2'b0, item_reg.offset} + range_len;
        end_off   = range_end;
        mask      = (25'd1 << block_shift_reg) - 25'd1;
        first_w   = {2'b0, item_reg.offset} >> block_shift_reg;
        last_w    = (range_end - 26'd1) >> block_shift_reg;
        cap_w     = ({1'b0, part_size_reg} - 26'd1) >> block_shift_reg;
        lim_w     = (item_reg.length == '0) ? first_w : last_w;
        if (lim_w > cap_w) lim_w = cap_w;
        if (lim_w > 26'(NUM_BLOCKS - 1)) lim_w = 26'(NUM_BLOCKS - 1);
    end

    // Classification of a read state for the check pass.
    logic cur_head, cur_tail, cur_bad;
    always_comb begin
        cur_head = head_reg && (idx_reg == first_reg);
        cur_tail = tail_reg && (idx_reg == last_reg);
        cur_bad  = 1'b0;
        case (item_reg.cmd)
            bsrt_pkg::CMD_RCHECK:
                cur_bad = (rd_data == bsrt_pkg::ST_NDEF) || (rd_data == bsrt_pkg::ST_INIT);
            bsrt_pkg::CMD_WCHECK:
                if (cur_head || cur_tail) begin
                    cur_bad = (rd_data == bsrt_pkg::ST_NDEF) ||
                              (rd_data == bsrt_pkg::ST_INIT);
                end else begin
                    cur_bad = (rd_data == bsrt_pkg::ST_INIT);
                end
            bsrt_pkg::CMD_COMMIT:
                if (cur_head) begin
                    cur_bad = (rd_data == bsrt_pkg::ST_NDEF) ||
                              (rd_data == bsrt_pkg::ST_INIT);
                end else begin
                    cur_bad = (rd_data == bsrt_pkg::ST_INIT);
                end
            default: cur_bad = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bsrt_pkg::FSM_IDLE:
                if (s_valid && s_ready) state_next = bsrt_pkg::FSM_SETUP;
            bsrt_pkg::FSM_CLEAR:
                if (idx_reg == 17'(NUM_BLOCKS - 1)) state_next = bsrt_pkg::FSM_IDLE;
            bsrt_pkg::FSM_SETUP:
                state_next = finish ? bsrt_pkg::FSM_DONE : bsrt_pkg::FSM_CHK_RD;
            bsrt_pkg::FSM_CHK_RD:   state_next = bsrt_pkg::FSM_CHK_WAIT;
            bsrt_pkg::FSM_CHK_WAIT: state_next = finish ? bsrt_pkg::FSM_DONE
                                               : (idx_next == idx_reg) ? bsrt_pkg::FSM_UPD_RD
                                               : bsrt_pkg::FSM_CHK_RD;
            bsrt_pkg::FSM_UPD_RD:   state_next = finish ? bsrt_pkg::FSM_DONE
                                                        : bsrt_pkg::FSM_UPD_WAIT;
            bsrt_pkg::FSM_UPD_WAIT: state_next = finish ? bsrt_pkg::FSM_DONE
                                                        : bsrt_pkg::FSM_UPD_RD;
            bsrt_pkg::FSM_LB_RD:    state_next = finish ? bsrt_pkg::FSM_DONE
                                                        : bsrt_pkg::FSM_LB_WAIT;
            bsrt_pkg::FSM_LB_WAIT:  state_next = finish ? bsrt_pkg::FSM_DONE
                                                        : bsrt_pkg::FSM_LB_RD;
            bsrt_pkg::FSM_DONE:     state_next = bsrt_pkg::FSM_IDLE;
            default:                state_next = bsrt_pkg::FSM_IDLE;
        endcase
        if (finish) state_next = bsrt_pkg::FSM_DONE;
    end

    // Datapath and outputs of the sequencer.
    always_comb begin
        req       = '0;
        idx_next  = idx_reg;
        did_next  = did_reg;
        nbytes_next = nbytes_reg;
        finish    = 1'b0;
        res       = out_reg;
        case (state_reg)
            bsrt_pkg::FSM_CLEAR: begin
                req.wr_en   = 1'b1;
                req.wr_addr = idx_reg[15:0];
                req.wr_data = bsrt_pkg::ST_NDEF;
                idx_next    = idx_reg + 17'd1;
            end
            bsrt_pkg::FSM_SETUP: begin
                res = '0;
                idx_next = first_w[16:0];
                case (item_reg.cmd)
                    bsrt_pkg::CMD_RCHECK, bsrt_pkg::CMD_WCHECK: begin
                        if ({2'b0, item_reg.offset} >= {1'b0, part_size_reg}) begin
                            res.status = bsrt_pkg::S_BOUNDS;
                            finish = 1'b1;
                        end else begin
                            res.phys_addr = ({12'b0, phys_base_reg} << PSH) +
                                            {16'b0, item_reg.offset};
                            res.byte_count = chk_size[24:0];
                            if (!track_reg || chk_size == '0) begin
                                finish = 1'b1;
                            end else if (last_w >= 26'(NUM_BLOCKS)) begin
                                res.status = bsrt_pkg::S_BOUNDS;
                                res.phys_addr = '0;
                                res.byte_count = '0;
                                finish = 1'b1;
                            end
                        end
                    end
                    bsrt_pkg::CMD_COMMIT, bsrt_pkg::CMD_MARK: begin
                        if (range_end > {1'b0, part_size_reg}) begin
                            res.status = bsrt_pkg::S_ILLEGAL;
                            finish = 1'b1;
                        end else if (!track_reg || item_reg.length == '0) begin
                            res.byte_count = item_reg.length;
                            finish = 1'b1;
                        end else if (last_w >= 26'(NUM_BLOCKS)) begin
                            res.status = bsrt_pkg::S_BOUNDS;
                            finish = 1'b1;
                        end
                    end
                    bsrt_pkg::CMD_LBEGIN: begin
                        if ({2'b0, item_reg.offset} >= {1'b0, part_size_reg} || !track_reg) begin
                            res.status = bsrt_pkg::S_ILLEGAL;
                            finish = 1'b1;
                        end else if (first_w >= 26'(NUM_BLOCKS)) begin
                            res.status = bsrt_pkg::S_BOUNDS;
                            finish = 1'b1;
                        end
                    end
                    bsrt_pkg::CMD_LFIN: begin
                        if (pend_count_reg == '0) begin
                            res.status = bsrt_pkg::S_ILLEGAL;
                            finish = 1'b1;
                        end else begin
                            res.first_block = pend_first_reg[9:0];
                            res.block_count = pend_count_reg[10:0];
                            idx_next = {1'b0, pend_first_reg};
                        end
                    end
                    default: begin
                        res.status = bsrt_pkg::S_ILLEGAL;
                        finish = 1'b1;
                    end
                endcase
                did_next  = 1'b0;
                nbytes_next = item_reg.length;
            end
            bsrt_pkg::FSM_CHK_RD: begin
                req.rd_en   = 1'b1;
                req.rd_addr = idx_reg[15:0];
                // Mark and load finish need no check pass.
                if (item_reg.cmd == bsrt_pkg::CMD_MARK || item_reg.cmd == bsrt_pkg::CMD_LFIN) begin
                    req.rd_en = 1'b0;
                end
            end
            bsrt_pkg::FSM_CHK_WAIT: begin
                if (item_reg.cmd == bsrt_pkg::CMD_LBEGIN) begin
                    if (rd_data == bsrt_pkg::ST_LOAD || rd_data == bsrt_pkg::ST_CHNG) begin
                        res.status = bsrt_pkg::S_ILLEGAL;
                        finish = 1'b1;
                    end else if (rd_data == bsrt_pkg::ST_INIT || pend_count_reg != '0) begin
                        res.status = bsrt_pkg::S_WAIT;
                        finish = 1'b1;
                    end
                end else if (item_reg.cmd == bsrt_pkg::CMD_MARK ||
                             item_reg.cmd == bsrt_pkg::CMD_LFIN) begin
                    idx_next = idx_reg;
                end else begin
                    if (cur_bad) begin
                        if (item_reg.cmd == bsrt_pkg::CMD_COMMIT) begin
                            res.status = bsrt_pkg::S_ILLEGAL;
                            finish = 1'b1;
                        end else begin
                            res.status = bsrt_pkg::S_NOTLOADED;
                        end
                    end
                    if (!finish) begin
                        if (idx_reg == last_reg) begin
                            if (is_check) finish = 1'b1;
                            idx_next = first_reg;
                        end else begin
                            idx_next = idx_reg + 17'd1;
                        end
                    end
                end
            end
            bsrt_pkg::FSM_UPD_RD: begin
                req.rd_en   = 1'b1;
                req.rd_addr = idx_reg[15:0];
                if (item_reg.cmd == bsrt_pkg::CMD_LFIN) begin
                    req.rd_en   = 1'b0;
                    req.wr_en   = (idx_reg < 17'(NUM_BLOCKS));
                    req.wr_addr = idx_reg[15:0];
                    req.wr_data = item_reg.load_ok ? bsrt_pkg::ST_LOAD : bsrt_pkg::ST_NDEF;
                    if (idx_reg + 17'd1 == {1'b0, pend_first_reg} + pend_count_reg) begin
                        finish = 1'b1;
                    end else begin
                        idx_next = idx_reg + 17'd1;
                    end
                end else if (item_reg.cmd == bsrt_pkg::CMD_LBEGIN) begin
                    // The index stays on the first block; the lookahead reads idx + 1.
                    req.rd_en   = 1'b0;
                    req.wr_en   = 1'b1;
                    req.wr_addr = idx_reg[15:0];
                    req.wr_data = bsrt_pkg::ST_INIT;
                    if (idx_reg >= limit_reg) begin
                        finish = 1'b1;
                        res.first_block = first_reg[9:0];
                        res.block_count = 11'(idx_reg - first_reg + 17'd1);
                    end
                end
            end
            bsrt_pkg::FSM_UPD_WAIT: begin
                req.wr_addr = idx_reg[15:0];
                req.wr_data = bsrt_pkg::ST_CHNG;
                if (item_reg.cmd == bsrt_pkg::CMD_MARK) begin
                    if (rd_data != bsrt_pkg::ST_CHNG) begin
                        req.wr_en = 1'b1;
                        did_next = 1'b1;
                    end
                end else begin
                    if (cur_head) begin
                        if (rd_data == bsrt_pkg::ST_LOAD) begin
                            req.wr_en = 1'b1;
                            did_next = 1'b1;
                        end
                    end else if (cur_tail) begin
                        if (rd_data == bsrt_pkg::ST_NDEF) begin
                            nbytes_next = 25'(({9'b0, last_reg[15:0]} << block_shift_reg) -
                                              {1'b0, item_reg.offset});
                        end else if (rd_data == bsrt_pkg::ST_LOAD) begin
                            req.wr_en = 1'b1;
                            did_next = 1'b1;
                        end
                    end else if (rd_data != bsrt_pkg::ST_CHNG) begin
                        req.wr_en = 1'b1;
                        did_next = 1'b1;
                    end
                end
                if (idx_reg == last_reg) begin
                    finish = 1'b1;
                    res.byte_count = (item_reg.cmd == bsrt_pkg::CMD_MARK) ?
                                     item_reg.length : nbytes_next;
                    res.enqueue_changed = did_next && save_reg && !part_changed_reg;
                end else begin
                    idx_next = idx_reg + 17'd1;
                end
            end
            bsrt_pkg::FSM_LB_RD: begin
                req.rd_en   = 1'b1;
                req.rd_addr = idx_reg[15:0] + 16'd1;
            end
            bsrt_pkg::FSM_LB_WAIT: begin
                if (idx_reg < limit_reg && rd_data == bsrt_pkg::ST_NDEF) begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = idx_reg[15:0] + 16'd1;
                    req.wr_data = bsrt_pkg::ST_INIT;
                    idx_next = idx_reg + 17'd1;
                end else begin
                    finish = 1'b1;
                    res.first_block = first_reg[9:0];
                    res.block_count = 11'(idx_reg - first_reg + 17'd1);
                end
            end
            default: ;
        endcase
    end

    bsrt_pkg::fsm_t state_go;
    always_comb begin
        state_go = state_next;
        if (state_reg == bsrt_pkg::FSM_CHK_WAIT && !finish) begin
            case (item_reg.cmd)
                bsrt_pkg::CMD_LBEGIN: state_go = bsrt_pkg::FSM_UPD_RD;
                bsrt_pkg::CMD_MARK, bsrt_pkg::CMD_LFIN: state_go = bsrt_pkg::FSM_UPD_RD;
                bsrt_pkg::CMD_COMMIT:
                    state_go = (idx_reg == last_reg) ? bsrt_pkg::FSM_UPD_RD
                                                     : bsrt_pkg::FSM_CHK_RD;
                default: state_go = bsrt_pkg::FSM_CHK_RD;
            endcase
        end
        if (state_reg == bsrt_pkg::FSM_UPD_RD && !finish &&
            item_reg.cmd == bsrt_pkg::CMD_LBEGIN) begin
            // After the first block, go to lookahead reading.
            state_go = bsrt_pkg::FSM_LB_RD;
        end
        if (state_reg == bsrt_pkg::FSM_UPD_RD && !finish &&
            item_reg.cmd == bsrt_pkg::CMD_LFIN) begin
            state_go = bsrt_pkg::FSM_UPD_RD;
        end
        if (finish) state_go = bsrt_pkg::FSM_DONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= bsrt_pkg::FSM_CLEAR;
            idx_reg          <= '0;
            out_valid_reg    <= 1'b0;
            part_changed_reg <= 1'b0;
            maybe_init_reg   <= 1'b0;
            pend_first_reg   <= '0;
            pend_count_reg   <= '0;
            did_reg          <= 1'b0;
        end else begin
            state_reg <= state_go;
            idx_reg   <= idx_next;
            did_reg   <= did_next;
            if (s_valid && s_ready) begin
                item_reg <= s_item;
            end
            if (state_reg == bsrt_pkg::FSM_SETUP) begin
                first_reg  <= first_w[16:0];
                last_reg   <= last_w[16:0];
                head_reg   <= ({1'b0, item_reg.offset} & mask) != '0;
                tail_reg   <= (end_off[24:0] & mask) != '0;
                limit_reg  <= lim_w[16:0];
            end
            nbytes_reg <= nbytes_next;
            if (finish) begin
                out_reg       <= res;
                out_valid_reg <= 1'b1;
                if (res.enqueue_changed) part_changed_reg <= 1'b1;
                if (item_reg.cmd == bsrt_pkg::CMD_LBEGIN && res.status == bsrt_pkg::S_OK) begin
                    maybe_init_reg <= 1'b1;
                    pend_first_reg <= first_reg[15:0];
                    pend_count_reg <= idx_reg - first_reg + 17'd1;
                end
                if (item_reg.cmd == bsrt_pkg::CMD_LFIN && res.status == bsrt_pkg::S_OK) begin
                    pend_first_reg <= '0;
                    pend_count_reg <= '0;
                end
            end else if (state_reg != bsrt_pkg::FSM_IDLE &&
                         state_reg != bsrt_pkg::FSM_CLEAR) begin
                out_reg <= res;
            end
            if (out_valid_reg && m_ready && !finish) out_valid_reg <= 1'b0;
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> state_reg == bsrt_pkg::FSM_IDLE && !out_valid_reg)
        else $error("item accepted while busy");
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");
    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_count_reg <= 17'(NUM_BLOCKS))
        else $error("pending load exceeds store");
    a_pending_started: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_count_reg != '0 |-> maybe_init_reg)
        else $error("pending load without a started load");
endmodule
